// ===== sv/packet_deframer_crc_seq_ack_macros.svh =====
`ifndef PACKET_DEFRAMER_CRC_SEQ_ACK_MACROS_SVH
`define PACKET_DEFRAMER_CRC_SEQ_ACK_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pdf_pkg.sv =====
package pdf_pkg;

	localparam int MAX_PACKET_BYTES = 64;
	localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
	localparam int FILL_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int BANK_ADDR_W = ADDR_W + 1;
	localparam int HDR_BYTES = 5;
	localparam int OUT_PLEN_W = 6;
	localparam int TDATA_W = 48;

	localparam logic [FILL_W-1:0] MIN_LEN = FILL_W'(5);
	localparam logic [16:0] FRAME_OVERHEAD = 17'd5;
	localparam logic [FILL_W-1:0] PAYLOAD_TRIM = FILL_W'(6);
	localparam logic [FILL_W-1:0] PAYLOAD_OFS = FILL_W'(4);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PACKET_BYTES);

	localparam logic [7:0] KNOCK_0 = 8'h2A;
	localparam logic [7:0] KNOCK_1 = 8'h23;
	localparam logic [7:0] START_CODE_RESET = 8'd42;
	localparam logic [7:0] ACK_TYPE_RESET = 8'd0;
	localparam logic [7:0] ACK_SIZE_LO = 8'd2;
	localparam logic [7:0] ACK_SIZE_HI = 8'd0;

	typedef enum logic [7:0] {
		REG_START_CODE = 8'd0,
		REG_ACK_TYPE   = 8'd1
	} reg_idx_t;

	typedef enum logic [3:0] {
		VERD_OK        = 4'd0,
		VERD_KNOCK     = 4'd1,
		VERD_BAD_START = 4'd2,
		VERD_SHORT     = 4'd3,
		VERD_LENGTH    = 4'd4,
		VERD_CRC       = 4'd5,
		VERD_SEQUENCE  = 4'd6,
		VERD_OVERFLOW  = 4'd7,
		VERD_ZERO_SIZE = 4'd8
	} verdict_t;

	typedef struct packed {
		logic              bank;
		verdict_t          verdict;
		logic [7:0]        seq;
		logic [FILL_W-1:0] plen;
	} desc_t;

	typedef struct packed {
		logic                   en;
		logic [BANK_ADDR_W-1:0] addr;
		logic [7:0]             data;
	} wr_req_t;

	typedef struct packed {
		logic                  kind;
		verdict_t              verdict;
		logic [7:0]            seq;
		logic [15:0]           ack_crc;
		logic [OUT_PLEN_W-1:0] plen;
		logic [7:0]            data;
		logic                  last;
	} out_item_t;

	// CRC-16 XModem, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		x = {crc[7:0], crc[15:8]} ^ {8'h00, b};
		x = x ^ {12'h000, x[7:4]};
		x = x ^ {x[3:0], 12'h000};
		x = x ^ {3'b000, x[7:0], 5'b00000};
		return x;
	endfunction

	localparam logic [15:0] ACK_CRC_PREFIX = crc_step(crc_step(16'h0000, ACK_SIZE_LO), ACK_SIZE_HI);

endpackage

// ===== sv/pdf_store.sv =====
module pdf_store (
	input  logic                           clk,
	input  pdf_pkg::wr_req_t               wr,
	input  logic [pdf_pkg::BANK_ADDR_W-1:0] rd_addr,
	output logic [7:0]                     rd_data
);
	import pdf_pkg::*;

	logic [7:0] mem_q [2*MAX_PACKET_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/pdf_queue.sv =====
module pdf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pdf_pkg::desc_t  push_desc,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output pdf_pkg::desc_t  head
);
	import pdf_pkg::*;

	desc_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

endmodule

// ===== sv/pdf_front.sv =====
module pdf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic [7:0]       start_code,
	output pdf_pkg::wr_req_t wr,
	input  logic             q_full,
	output logic             push,
	output pdf_pkg::desc_t   push_desc
);
	import pdf_pkg::*;

	logic [FILL_W-1:0] fill_q;
	logic [15:0]       crc_q;
	logic              ovf_q;
	logic [7:0]        exp_seq_q;
	logic              bank_q;
	logic [7:0]        hdr_q [HDR_BYTES];

	logic              accept;
	logic              room;
	logic [FILL_W-1:0] fill_next;
	logic [15:0]       crc_next;
	logic              ovf_next;
	logic [7:0]        hdr_next [HDR_BYTES];
	logic [15:0]       size;
	logic [FILL_W-1:0] plen;
	verdict_t          verdict;

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;
	assign room     = (fill_q < FILL_MAX);

	always_comb begin
		for (int i = 0; i < HDR_BYTES; i++) begin
			hdr_next[i] = (fill_q == FILL_W'(i)) ? in_byte : hdr_q[i];
		end
	end

	assign fill_next = room ? fill_q + FILL_W'(1) : fill_q;
	assign crc_next  = (room && fill_q != '0) ? crc_step(crc_q, in_byte) : crc_q;
	assign ovf_next  = ovf_q | ~room;
	assign size      = {hdr_next[2], hdr_next[1]};
	assign plen      = fill_next - PAYLOAD_TRIM;

	always_comb begin
		if (ovf_next) begin
			verdict = VERD_OVERFLOW;
		end else if (hdr_next[0] != start_code) begin
			verdict = VERD_BAD_START;
		end else if (fill_next < MIN_LEN) begin
			verdict = VERD_SHORT;
		end else if (size == 16'd0) begin
			verdict = (hdr_next[3] == KNOCK_0 && hdr_next[4] == KNOCK_1) ?
				VERD_KNOCK : VERD_ZERO_SIZE;
		end else if ({1'b0, size} + FRAME_OVERHEAD != 17'(fill_next)) begin
			verdict = VERD_LENGTH;
		end else if (crc_next != 16'd0) begin
			verdict = VERD_CRC;
		end else if (hdr_next[3] != exp_seq_q) begin
			verdict = VERD_SEQUENCE;
		end else begin
			verdict = VERD_OK;
		end
	end

	assign push              = accept & in_last;
	assign push_desc.bank    = bank_q;
	assign push_desc.verdict = verdict;
	assign push_desc.seq     = (verdict == VERD_OK) ? exp_seq_q : 8'd0;
	assign push_desc.plen    = (verdict == VERD_OK) ? plen : '0;

	assign wr.en   = accept & room;
	assign wr.addr = {bank_q, fill_q[ADDR_W-1:0]};
	assign wr.data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			crc_q     <= 16'd0;
			ovf_q     <= 1'b0;
			exp_seq_q <= 8'd0;
			bank_q    <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				fill_q <= '0;
				crc_q  <= 16'd0;
				ovf_q  <= 1'b0;
				bank_q <= ~bank_q;
				if (verdict == VERD_OK) begin
					exp_seq_q <= exp_seq_q + 8'd1;
				end
			end else begin
				fill_q <= fill_next;
				crc_q  <= crc_next;
				ovf_q  <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr_q[i] <= hdr_next[i];
			end
		end
	end

endmodule

// ===== sv/pdf_back.sv =====
module pdf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  pdf_pkg::desc_t                  head,
	output logic                            pop,
	input  logic [7:0]                      ack_type,
	output logic [pdf_pkg::BANK_ADDR_W-1:0] rd_addr,
	input  logic [7:0]                      rd_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pdf_pkg::out_item_t              out_item
);
	import pdf_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_DATA
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic [FILL_W-1:0] idx_q;

	logic        slot_free;
	logic        head_only;
	logic        head_ok;
	logic        data_last;
	logic        load;
	logic [15:0] ack_crc;

	assign slot_free = ~out_valid_q | out_ready;
	assign head_ok   = (head.verdict == VERD_OK);
	assign head_only = (head.verdict != VERD_OK) || (head.plen == '0);
	assign data_last = (idx_q == head.plen - FILL_W'(1));
	assign rd_addr   = {head.bank, ADDR_W'(idx_q + PAYLOAD_OFS)};
	assign ack_crc   = crc_step(crc_step(ACK_CRC_PREFIX, head.seq), ack_type);

	always_comb begin
		case (state_q)
			B_IDLE:  pop = head_valid & slot_free & head_only;
			B_DATA:  pop = slot_free & data_last;
			default: pop = 1'b0;
		endcase
	end

	always_comb begin
		case (state_q)
			B_IDLE:  load = head_valid & slot_free;
			B_DATA:  load = slot_free;
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (load) begin
						out_q <= '{
							kind:    1'b0,
							verdict: head.verdict,
							seq:     head_ok ? head.seq : 8'd0,
							ack_crc: head_ok ? ack_crc : 16'd0,
							plen:    head_ok ? OUT_PLEN_W'(head.plen) : OUT_PLEN_W'(0),
							data:    8'd0,
							last:    head_only
						};
						idx_q <= '0;
						if (!head_only) begin
							state_q <= B_READ;
						end
					end
				end
				B_READ: begin
					state_q <= B_DATA;
				end
				B_DATA: begin
					if (load) begin
						out_q <= '{
							kind:    1'b1,
							verdict: VERD_OK,
							seq:     8'd0,
							ack_crc: 16'd0,
							plen:    OUT_PLEN_W'(0),
							data:    rd_data,
							last:    data_last
						};
						if (data_last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_q + FILL_W'(1);
							state_q <= B_READ;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/packet_deframer_crc_seq_ack.sv =====
// Path: the verdict word goes through the descriptor queue and output register
// after the last input word; each payload word is read in B_READ, sent in B_DATA.
// Input: 1 word per cycle while a packet store bank is free; two banks, so one
// packet can be received while the previous one is still being replayed.
// Reset: arst_n clears counters, queue, sequence number and config to defaults;
// the packet store is not cleared.
module packet_deframer_crc_seq_ack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // rx_byte
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// verdict[3:0], seq_number[11:4], ack_crc[27:12], payload_len[33:28],
	// data_byte[41:34], zero[47:42]
	output logic [pdf_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast,
	output logic                        m_axis_tuser,  // kind
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [7:0]                  cfg_index,
	input  logic [7:0]                  cfg_data
);
	import pdf_pkg::*;

	logic [7:0] start_code_q;
	logic [7:0] ack_type_q;

	wr_req_t                wr;
	logic [BANK_ADDR_W-1:0] rd_addr;
	logic [7:0]             rd_data;
	logic                   q_full;
	logic                   push;
	desc_t                  push_desc;
	logic                   pop;
	logic                   head_valid;
	desc_t                  head;
	out_item_t              out_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RESET;
			ack_type_q   <= ACK_TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_CODE: start_code_q <= cfg_data;
				REG_ACK_TYPE:   ack_type_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	pdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.start_code (start_code_q),
		.wr         (wr),
		.q_full     (q_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	pdf_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	pdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ack_type   (ack_type_q),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_item   (out_item)
	);

	assign m_axis_tdata = {6'd0, out_item.data, out_item.plen, out_item.ack_crc,
		out_item.seq, out_item.verdict};
	assign m_axis_tlast = out_item.last;
	assign m_axis_tuser = out_item.kind;

endmodule

// ===== sv/pdf_chk.sv =====
`include "packet_deframer_crc_seq_ack_macros.svh"

module pdf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	`PDF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output word changed while stalled")
	`PDF_ASSERT_IMPLY(a_payload_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[33:0] == 34'd0 && m_axis_tdata[47:42] == 6'd0, "payload word carries verdict fields")
	`PDF_ASSERT_IMPLY(a_reject_last, clk, arst_n, m_axis_tvalid && !m_axis_tuser && m_axis_tdata[3:0] != 4'd0, m_axis_tlast && m_axis_tdata[47:4] == 44'd0, "rejection verdict not a lone last word")
	`PDF_ASSERT_IMPLY(a_accept_tail, clk, arst_n, m_axis_tvalid && !m_axis_tuser && m_axis_tdata[3:0] == 4'd0, m_axis_tlast == (m_axis_tdata[33:28] == 6'd0), "accept verdict last flag disagrees with payload length")
	`PDF_ASSERT_IMPLY(a_verdict_range, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[3:0] <= 4'd8, "verdict code out of range")

endmodule

bind packet_deframer_crc_seq_ack pdf_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
